### rtl/core/cle_pkg.sv
// Shared types, key codes and the colour menu table for the console line editor.
package cle_pkg;

  // Default ring depth
  localparam int LINE_DEPTH_DEF = 128;

  // Reader status codes
  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_EMPTY = 2'd1,
    RD_CHAR  = 2'd2,
    RD_EOF   = 2'd3
  } rd_status_t;

  // Echo codes
  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CHAR  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_kind_t;

  // Item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Key codes
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7F;
  localparam logic [7:0] KEY_UP_LO  = 8'h77; // w
  localparam logic [7:0] KEY_UP_HI  = 8'h57; // W
  localparam logic [7:0] KEY_DN_LO  = 8'h73; // s
  localparam logic [7:0] KEY_DN_HI  = 8'h53; // S

  localparam logic [7:0] TOGGLE_KEY_RST = 8'hFF;
  localparam logic [7:0] ATTR_RST       = 8'h07; // white on black

  // Attribute applied by each menu row
  function automatic logic [7:0] row_attr(input logic [1:0] row);
    logic [7:0] attr;
    case (row)
      2'd0:    attr = 8'h07;
      2'd1:    attr = 8'h75;
      2'd2:    attr = 8'h34;
      default: attr = 8'h67;
    endcase
    return attr;
  endfunction

endpackage

### rtl/core/cle_if.sv
// Valid/ready channel interfaces for the console line editor input and result streams.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_code;
  logic       read_in_progress;

  modport source (output valid, kind, key_code, read_in_progress, input ready);
  modport sink   (input valid, kind, key_code, read_in_progress, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] read_status;
  logic [7:0] read_char;
  logic       read_ends_call;
  logic [1:0] echo_kind;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       wake_reader;
  logic       procdump_request;
  logic       menu_shown;
  logic [1:0] menu_row;
  logic [7:0] text_attr;

  modport source (output valid, read_status, read_char, read_ends_call, echo_kind,
                  echo_char, erase_count, wake_reader, procdump_request, menu_shown,
                  menu_row, text_attr, input ready);
  modport sink   (input valid, read_status, read_char, read_ends_call, echo_kind,
                  echo_char, erase_count, wake_reader, procdump_request, menu_shown,
                  menu_row, text_attr, output ready);
endinterface

### rtl/core/console_line_editor.sv
// Console line editor: canonical line discipline over a character ring, with colour menu.
//
// Usage:
//   in_ch carries one transaction per key (kind 0, key_code) or per one-character
//   read (kind 1, read_in_progress). out_ch returns exactly one result transaction
//   for each input transaction, in order: read status and character, echo or erase
//   request, reader wakeup, process dump request, and the menu/attribute state.
//   cfg_we/cfg_wdata set the menu toggle key; write it only while the block is idle.
// Flow: an accepted transaction is held in the input register, then moves into the
//   result register once that register is free to take it.
//   Throughput: one transaction per cycle while out_ch.ready stays high; the ring head character is prefetched
//   from the line store every cycle, with a write bypass, so a read sees a key
//   typed in the previous cycle.
// Reset (rst, synchronous): ring positions cleared, menu closed on row 0,
//   attribute 0x07, toggle key 0xFF. The line store is not cleared; only
//   committed entries are ever read.
// Stall: while out_ch.ready is low the result register holds; the input register
//   still takes one transaction, then in_ch.ready drops until the result moves.
module console_line_editor #(
  parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  cle_in_if.sink        in_ch,
  cle_out_if.source     out_ch
);
  import cle_pkg::*;

  localparam int PosMod = 2 * LINE_DEPTH;
  localparam int PW     = $clog2(PosMod);
  localparam int SW     = $clog2(LINE_DEPTH);
  localparam logic [PW-1:0] PosMax = PW'(PosMod - 1);
  localparam logic [PW-1:0] DepthP = PW'(LINE_DEPTH);

  // Position helpers, positions run modulo 2*LINE_DEPTH
  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == PosMax) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
    return (p == '0) ? PosMax : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    t = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + (PW+1)'(PosMod) - {1'b0, b};
    return t[PW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DepthP) ? p - DepthP : p;
    return s[SW-1:0];
  endfunction

  // Configuration
  logic [7:0] toggle_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_key <= TOGGLE_KEY_RST;
    end else if (cfg_we) begin
      toggle_key <= cfg_wdata;
    end
  end

  // Input register
  logic       in_vld;
  logic       in_kind;
  logic [7:0] in_key;
  logic       in_rip;
  logic       out_vld;
  logic       advance;

  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_kind <= in_ch.kind;
      in_key  <= in_ch.key_code;
      in_rip  <= in_ch.read_in_progress;
    end
  end

  // Editor state
  logic [PW-1:0] read_pos, commit_pos, edit_pos;
  logic [PW-1:0] read_pos_next, commit_pos_next, edit_pos_next;
  logic          menu_open, menu_open_next;
  logic [1:0]    menu_choice, menu_choice_next;
  logic [7:0]    colour_attr, colour_attr_next;

  // Line store with prefetched head character
  logic [7:0]    line_store [LINE_DEPTH];
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [SW-1:0] rd_addr;
  logic [7:0]    mem_rd;
  logic          byp;
  logic [7:0]    byp_data;
  logic [7:0]    head_char;

  assign rd_addr   = slot_of(read_pos_next);
  assign head_char = byp ? byp_data : mem_rd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
    mem_rd   <= line_store[rd_addr];
    byp      <= wr_en && (wr_addr == rd_addr);
    byp_data <= wr_data;
  end

  // Result fields of the item in the input register
  rd_status_t  r_status;
  logic [7:0]  r_char;
  logic        r_ends;
  echo_kind_t  r_echo;
  logic [7:0]  r_echo_char;
  logic [7:0]  r_erase;
  logic        r_wake;
  logic        r_pdump;

  // Key and read processing
  always_comb begin
    logic [7:0]    c;
    logic [PW-1:0] n;
    logic [PW-1:0] ep;

    read_pos_next    = read_pos;
    commit_pos_next  = commit_pos;
    edit_pos_next    = edit_pos;
    menu_open_next   = menu_open;
    menu_choice_next = menu_choice;
    colour_attr_next = colour_attr;
    wr_en       = 1'b0;
    wr_addr     = slot_of(edit_pos);
    wr_data     = in_key;
    r_status    = RD_NONE;
    r_char      = '0;
    r_ends      = 1'b0;
    r_echo      = ECHO_NONE;
    r_echo_char = '0;
    r_erase     = '0;
    r_wake      = 1'b0;
    r_pdump     = 1'b0;
    c  = in_key;
    n  = pos_diff(edit_pos, commit_pos);
    ep = pos_inc(edit_pos);

    if (advance) begin
      if (in_kind == KIND_KEY) begin
        if (c == toggle_key) begin
          menu_open_next = !menu_open;
        end else if (menu_open) begin
          // menu navigation swallows all other keys
          if (c inside {KEY_UP_LO, KEY_UP_HI}) begin
            menu_choice_next = menu_choice - 2'd1;
          end else if (c inside {KEY_DN_LO, KEY_DN_HI}) begin
            menu_choice_next = menu_choice + 2'd1;
          end else if (c inside {KEY_LF, KEY_CR}) begin
            colour_attr_next = row_attr(menu_choice);
            menu_open_next   = 1'b0;
          end
        end else if (c == KEY_CTRL_P) begin
          r_pdump = 1'b1;
        end else if (c == KEY_CTRL_U) begin
          if (n != '0) begin
            edit_pos_next = commit_pos;
            r_echo        = ECHO_ERASE;
            r_erase       = (32'(n) > 32'd255) ? 8'd255 : 8'(n);
          end
        end else if (c inside {KEY_CTRL_H, KEY_DEL}) begin
          if (n != '0) begin
            edit_pos_next = pos_dec(edit_pos);
            r_echo        = ECHO_ERASE;
            r_erase       = 8'd1;
          end
        end else if (c != KEY_NUL && pos_diff(edit_pos, read_pos) < DepthP) begin
          // ordinary key: store and echo, CR becomes LF
          if (c == KEY_CR) begin
            c = KEY_LF;
          end
          wr_en         = 1'b1;
          wr_data       = c;
          edit_pos_next = ep;
          r_echo        = ECHO_CHAR;
          r_echo_char   = c;
          if (c == KEY_LF || c == KEY_CTRL_D || pos_diff(ep, read_pos) == DepthP) begin
            commit_pos_next = ep;
            r_wake          = 1'b1;
          end
        end
      end else begin
        // one-character read
        if (read_pos == commit_pos) begin
          r_status = RD_EMPTY;
        end else if (head_char == KEY_CTRL_D) begin
          r_status = RD_EOF;
          if (!in_rip) begin
            read_pos_next = pos_inc(read_pos);
          end
        end else begin
          read_pos_next = pos_inc(read_pos);
          r_status      = RD_CHAR;
          r_char        = head_char;
          r_ends        = (head_char == KEY_LF);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos    <= '0;
      commit_pos  <= '0;
      edit_pos    <= '0;
      menu_open   <= 1'b0;
      menu_choice <= '0;
      colour_attr <= ATTR_RST;
    end else begin
      read_pos    <= read_pos_next;
      commit_pos  <= commit_pos_next;
      edit_pos    <= edit_pos_next;
      menu_open   <= menu_open_next;
      menu_choice <= menu_choice_next;
      colour_attr <= colour_attr_next;
    end
  end

  // Result register
  rd_status_t o_status;
  logic [7:0] o_char;
  logic       o_ends;
  echo_kind_t o_echo;
  logic [7:0] o_echo_char;
  logic [7:0] o_erase;
  logic       o_wake;
  logic       o_pdump;
  logic       o_menu;
  logic [1:0] o_row;
  logic [7:0] o_attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_status    <= r_status;
      o_char      <= r_char;
      o_ends      <= r_ends;
      o_echo      <= r_echo;
      o_echo_char <= r_echo_char;
      o_erase     <= r_erase;
      o_wake      <= r_wake;
      o_pdump     <= r_pdump;
      o_menu      <= menu_open_next;
      o_row       <= menu_choice_next;
      o_attr      <= colour_attr_next;
    end
  end

  assign out_ch.valid            = out_vld;
  assign out_ch.read_status      = o_status;
  assign out_ch.read_char        = o_char;
  assign out_ch.read_ends_call   = o_ends;
  assign out_ch.echo_kind        = o_echo;
  assign out_ch.echo_char        = o_echo_char;
  assign out_ch.erase_count      = o_erase;
  assign out_ch.wake_reader      = o_wake;
  assign out_ch.procdump_request = o_pdump;
  assign out_ch.menu_shown       = o_menu;
  assign out_ch.menu_row         = o_row;
  assign out_ch.text_attr        = o_attr;

  // Ring ordering: read <= commit <= edit <= read + depth
  logic ring_order_ok;
  assign ring_order_ok = (pos_diff(commit_pos, read_pos) <= pos_diff(edit_pos, read_pos)) &&
                         (pos_diff(edit_pos, read_pos) <= DepthP);

`ifndef ASSERT_OFF
  a_ring_order: assert property (@(posedge clk) disable iff (rst) ring_order_ok)
    else $error("ring positions out of order");

  a_wake_echo: assert property (@(posedge clk) disable iff (rst)
    out_vld && o_wake |-> o_echo == ECHO_CHAR)
    else $error("reader woken without a stored character");

  a_pdump_menu: assert property (@(posedge clk) disable iff (rst)
    out_vld && o_pdump |-> !o_menu)
    else $error("process dump raised while menu open");

  a_read_no_edit: assert property (@(posedge clk) disable iff (rst)
    advance && in_kind == KIND_READ |=> $stable(edit_pos) && $stable(commit_pos))
    else $error("read changed the edit or commit position");
`endif

endmodule

### tb/console_line_editor_tb.sv
// Self-checking testbench for the console line editor: directed and random keys and reads.
`timescale 1ns / 100ps

module console_line_editor_tb;
  import cle_pkg::*;

  localparam int DEPTH = LINE_DEPTH_DEF;
  localparam int PTR_W = $clog2(2 * DEPTH);
  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT = 200000;
  // Attribute per menu row, row 0 in the low byte
  localparam logic [31:0] MENU_ATTRS = {8'h67, 8'h34, 8'h75, 8'h07};

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
    logic       read_in_progress;
  } console_item_t;

  typedef struct packed {
    rd_status_t read_status;
    logic [7:0] read_char;
    logic       read_ends_call;
    echo_kind_t echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       wake_reader;
    logic       procdump_request;
    logic       menu_shown;
    logic [1:0] menu_row;
    logic [7:0] text_attr;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the editor state
  logic [7:0]       ring_mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] commit_ptr = '0;
  logic [PTR_W-1:0] edit_ptr = '0;
  logic             menu_on = 1'b0;
  logic [1:0]       menu_sel = 2'd0;
  logic [7:0]       attr_now = ATTR_RST;
  logic [7:0]       toggle_code = TOGGLE_KEY_RST;

  console_item_t key_read_queue [$];
  line_result_t  expected_results [$];
  console_item_t on_wire;

  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 81;
  int unsigned bad_results = 0;
  int unsigned cycle_count = 0;
  int unsigned items_made = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;

  // Apply one transaction to the shadow state and return the result it must produce
  function automatic line_result_t next_console_result(input console_item_t it);
    line_result_t     r;
    logic [7:0]       c;
    logic [PTR_W-1:0] span;
    r.read_status = RD_NONE;
    r.read_char = 8'h00;
    r.read_ends_call = 1'b0;
    r.echo_kind = ECHO_NONE;
    r.echo_char = 8'h00;
    r.erase_count = 8'h00;
    r.wake_reader = 1'b0;
    r.procdump_request = 1'b0;
    if (it.kind == KIND_KEY) begin
      c = it.key_code;
      if (c == toggle_code) begin
        menu_on = ~menu_on;
      end else if (menu_on) begin
        // menu swallows everything but navigation and enter
        if (c == KEY_UP_LO || c == KEY_UP_HI) begin
          menu_sel = menu_sel - 2'd1;
        end else if (c == KEY_DN_LO || c == KEY_DN_HI) begin
          menu_sel = menu_sel + 2'd1;
        end else if (c == KEY_LF || c == KEY_CR) begin
          attr_now = MENU_ATTRS[menu_sel*8 +: 8];
          menu_on = 1'b0;
        end
      end else if (c == KEY_CTRL_P) begin
        r.procdump_request = 1'b1;
      end else if (c == KEY_CTRL_U) begin
        span = edit_ptr - commit_ptr;
        if (span != 0) begin
          edit_ptr = commit_ptr;
          r.echo_kind = ECHO_ERASE;
          r.erase_count = (span > 255) ? 8'd255 : 8'(span);
        end
      end else if (c == KEY_CTRL_H || c == KEY_DEL) begin
        if (edit_ptr != commit_ptr) begin
          edit_ptr = edit_ptr - 1'b1;
          r.echo_kind = ECHO_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (c != KEY_NUL && PTR_W'(edit_ptr - rd_ptr) < DEPTH) begin
        // ordinary key, stored unless the ring is full
        if (c == KEY_CR) c = KEY_LF;
        ring_mem[edit_ptr % DEPTH] = c;
        edit_ptr = edit_ptr + 1'b1;
        r.echo_kind = ECHO_CHAR;
        r.echo_char = c;
        if (c == KEY_LF || c == KEY_CTRL_D || PTR_W'(edit_ptr - rd_ptr) == DEPTH) begin
          commit_ptr = edit_ptr;
          r.wake_reader = 1'b1;
        end
      end
    end else begin
      if (rd_ptr == commit_ptr) begin
        r.read_status = RD_EMPTY;
      end else begin
        c = ring_mem[rd_ptr % DEPTH];
        if (c == KEY_CTRL_D) begin
          // EOF; a read already in progress leaves the ^D for the next call
          if (!it.read_in_progress) rd_ptr = rd_ptr + 1'b1;
          r.read_status = RD_EOF;
        end else begin
          rd_ptr = rd_ptr + 1'b1;
          r.read_status = RD_CHAR;
          r.read_char = c;
          r.read_ends_call = (c == KEY_LF);
        end
      end
    end
    r.menu_shown = menu_on;
    r.menu_row = menu_sel;
    r.text_attr = attr_now;
    return r;
  endfunction

  function automatic string fmt_result(input line_result_t r);
    return $sformatf({"st=%0d ch=%h end=%b echo=%0d ech=%h erase=%0d",
                      " wake=%b pd=%b menu=%b row=%0d attr=%h"},
                     r.read_status, r.read_char, r.read_ends_call, r.echo_kind, r.echo_char,
                     r.erase_count, r.wake_reader, r.procdump_request, r.menu_shown,
                     r.menu_row, r.text_attr);
  endfunction

  task automatic compare_result(input line_result_t got, input line_result_t want);
    string bad;
    bad = "";
    if (got.read_status !== want.read_status) bad = {bad, " read_status"};
    if (got.read_char !== want.read_char) bad = {bad, " read_char"};
    if (got.read_ends_call !== want.read_ends_call) bad = {bad, " read_ends_call"};
    if (got.echo_kind !== want.echo_kind) bad = {bad, " echo_kind"};
    if (got.echo_char !== want.echo_char) bad = {bad, " echo_char"};
    if (got.erase_count !== want.erase_count) bad = {bad, " erase_count"};
    if (got.wake_reader !== want.wake_reader) bad = {bad, " wake_reader"};
    if (got.procdump_request !== want.procdump_request) bad = {bad, " procdump_request"};
    if (got.menu_shown !== want.menu_shown) bad = {bad, " menu_shown"};
    if (got.menu_row !== want.menu_row) bad = {bad, " menu_row"};
    if (got.text_attr !== want.text_attr) bad = {bad, " text_attr"};
    if (bad != "") begin
      bad_results++;
      if (bad_results <= 10) begin
        $display("cycle %0d: mismatch in%s", cycle_count, bad);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  // Input driver: presents queued transactions, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_results.push_back(next_console_result(on_wire));
      if (!in_ch.valid || in_ch.ready) begin
        if (key_read_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_wire = key_read_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= on_wire.kind;
          in_ch.key_code <= on_wire.key_code;
          in_ch.read_in_progress <= on_wire.read_in_progress;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_req
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end
  end

  // Result receiver
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    line_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.read_status = rd_status_t'(out_ch.read_status);
      got.read_char = out_ch.read_char;
      got.read_ends_call = out_ch.read_ends_call;
      got.echo_kind = echo_kind_t'(out_ch.echo_kind);
      got.echo_char = out_ch.echo_char;
      got.erase_count = out_ch.erase_count;
      got.wake_reader = out_ch.wake_reader;
      got.procdump_request = out_ch.procdump_request;
      got.menu_shown = out_ch.menu_shown;
      got.menu_row = out_ch.menu_row;
      got.text_attr = out_ch.text_attr;
      if (expected_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("cycle %0d: unexpected result %s", cycle_count, fmt_result(got));
      end else begin
        compare_result(got, expected_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_key(input logic [7:0] code);
    key_read_queue.push_back('{kind: KIND_KEY, key_code: code, read_in_progress: 1'b0});
    if (code != KEY_NUL || code == toggle_code) items_made++;
  endtask

  task automatic add_read(input logic in_progress);
    key_read_queue.push_back('{kind: KIND_READ, key_code: 8'($urandom_range(255)),
                               read_in_progress: in_progress});
    items_made++;
  endtask

  // One burst of user activity: a typed line, a run of reads, a menu visit or noise
  task automatic add_session();
    int         pick;
    int         len;
    int         k;
    bit         plain;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 40) begin
      plain = ($urandom_range(15) == 0);
      len = plain ? $urandom_range(100, 140) : $urandom_range(12);
      for (k = 0; k < len; k++) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (!plain) begin
          case ($urandom_range(19))
            0: c = $urandom_range(1) ? KEY_CTRL_H : KEY_DEL;
            1: c = KEY_CTRL_U;
            2: c = KEY_CTRL_P;
            3: c = 8'($urandom_range(1, 255));
            default: ;
          endcase
        end
        add_key(c);
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: add_key(KEY_LF);
        5, 6: add_key(KEY_CR);
        7, 8: add_key(KEY_CTRL_D);
        default: if ($urandom_range(1)) add_key(KEY_CTRL_U);
      endcase
    end else if (pick < 70) begin
      len = $urandom_range(1, 24);
      for (k = 0; k < len; k++) add_read(1'($urandom_range(1)));
    end else if (pick < 85) begin
      add_key(toggle_code);
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(4))
          0: add_key(KEY_UP_LO);
          1: add_key(KEY_UP_HI);
          2: add_key(KEY_DN_LO);
          3: add_key(KEY_DN_HI);
          default: add_key(8'($urandom_range(255)));
        endcase
      end
      case ($urandom_range(9))
        0, 1, 2: add_key(KEY_LF);
        3, 4, 5: add_key(KEY_CR);
        6, 7, 8: add_key(toggle_code);
        default: ;
      endcase
    end else begin
      len = $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(1)) add_read(1'($urandom_range(1)));
        else add_key(8'($urandom_range(255)));
      end
    end
  endtask

  // Wait until nothing is queued, on the wire or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (key_read_queue.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_toggle_key(input logic [7:0] code);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    toggle_code = code;
  endtask

  task automatic run_random_phase(input logic [7:0] code, input int unsigned tx_pct,
                                  input int unsigned rx_pct, input int unsigned count,
                                  input bit long_hold);
    int unsigned goal;
    int unsigned half;
    wait_idle();
    set_toggle_key(code);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = items_made + count;
    while (items_made < goal) add_session();
    if (long_hold) begin
      // stall the receiver midway while the sender keeps offering
      half = key_read_queue.size() / 2;
      while (key_read_queue.size() > half) @(negedge clk);
      hold_req = ~hold_req;
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_KEY;
    in_ch.key_code = 8'h00;
    in_ch.read_in_progress = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, ignored NUL, edits on an empty line, kill, dump request
    wait_idle();
    set_toggle_key(TOGGLE_KEY_RST);
    add_read(1'b0);
    add_key(KEY_NUL);
    add_key(8'h61);
    add_key(KEY_DEL);
    add_key(8'h80);
    add_key(KEY_CTRL_H);
    add_key(KEY_CTRL_H);
    add_key(KEY_CTRL_U);
    add_key(8'h78);
    add_key(8'hFE);
    add_key(KEY_CTRL_U);
    add_key(KEY_CTRL_P);
    // CR becomes LF and commits; then an EOF kept by a read in progress
    add_key(8'h7A);
    add_key(KEY_CR);
    add_read(1'b0);
    add_read(1'b1);
    add_key(KEY_CTRL_D);
    add_read(1'b1);
    add_read(1'b0);
    add_read(1'b0);
    // Menu: wrap both ways, swallowed key, enter applies, open and close
    add_key(TOGGLE_KEY_RST);
    add_key(KEY_UP_LO);
    add_key(KEY_UP_HI);
    add_key(KEY_DN_LO);
    add_key(KEY_DN_HI);
    add_key(KEY_DN_HI);
    add_key(8'h71);
    add_key(KEY_LF);
    add_key(TOGGLE_KEY_RST);
    add_key(TOGGLE_KEY_RST);

    run_random_phase(8'h00, 10, 81, 570, 1'b1);
    run_random_phase(8'h1B, 81, 10, 570, 1'b0);
    run_random_phase(KEY_CR, 0, 0, 570, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d bad results, %0d results missing", bad_results, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
